[rtl/lfr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LRU frame replacer.
// Used by the channel interfaces, the recency cell and the top level.
package lfr_pkg;

    localparam int FRAMES  = 64;
    localparam int ID_W    = 6;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int OP_W    = 2;
    localparam int LOG_FR  = $clog2(FRAMES);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_VICTIM = 2'd1,
        OP_ERASE  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    // Per-cell update command from the list controller.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

[rtl/lfr_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// Depends on lfr_pkg for field widths.
interface lfr_req_if;
    logic              valid;
    logic              ready;
    logic [lfr_pkg::OP_W-1:0] op;
    lfr_pkg::t_id      frame_id;

    modport source (output valid, output op, output frame_id, input ready);
    modport sink   (input valid, input op, input frame_id, output ready);
endinterface

interface lfr_rsp_if;
    logic              valid;
    logic              ready;
    logic              ok;
    lfr_pkg::t_id      victim_frame;
    lfr_pkg::t_cnt     occupancy;

    modport source (output valid, output ok, output victim_frame, output occupancy,
                    input ready);
    modport sink   (input valid, input ok, input victim_frame, input occupancy,
                    output ready);
endinterface

[rtl/lfr_cell.sv]
`timescale 1ns / 1ps
// One position of the recency list: holds a frame index and compares it with the key.
// Depends on lfr_pkg.
module lfr_cell (
    input  logic                i_clk,
    input  lfr_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  lfr_pkg::t_id        i_key,
    input  lfr_pkg::t_id        i_upper_id,
    output lfr_pkg::t_id        o_id,
    output logic                o_hit
);

    lfr_pkg::t_id r_id;
    lfr_pkg::t_id n_id;

    always_comb begin
        if (i_ctrl.load) begin
            n_id = i_key;
        end else if (i_ctrl.shift) begin
            n_id = i_upper_id;
        end else begin
            n_id = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id  = r_id;
    assign o_hit = i_valid && (r_id == i_key);

endmodule

[rtl/lru_frame_replacer.sv]
`timescale 1ns / 1ps
// LRU frame replacer top level: a row of recency cells plus presence flags and count.
// Depends on lfr_pkg, lfr_if and lfr_cell.
//
// The block keeps up to 64 frame indices in recency order in a row of cells,
// least recent at cell 0. Every operation (insert or refresh, take victim,
// erase) is resolved in the cycle it is accepted: all cells compare against
// the frame index at once, a prefix OR marks the cells at or above a hit, and each
// cell either holds, takes its upper neighbour's index or loads the new one.
// One request beat is accepted every cycle unless a full output register is held
// back, and its response beat appears there in the next cycle; a request is still
// taken while that register is full as long as the response is being taken in the
// same cycle. No clearing pass is needed after reset.
module lru_frame_replacer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfr_req_if.sink      i_req,
    lfr_rsp_if.source    o_rsp
);

    localparam int N = lfr_pkg::FRAMES;

    logic [N-1:0]              r_present;
    logic [N-1:0]              n_present;
    lfr_pkg::t_cnt             r_count;
    lfr_pkg::t_cnt             n_count;
    logic                      r_out_valid;
    logic                      r_ok;
    lfr_pkg::t_id              r_victim;
    logic                      n_ok;
    lfr_pkg::t_id              n_victim;

    lfr_pkg::t_id              ids  [N];
    logic [N-1:0]              hits;
    logic [N-1:0]              above;
    lfr_pkg::t_cell_ctrl       ctrl [N];

    logic                      accept;
    logic                      was_present;
    logic                      is_insert;
    logic                      is_victim;
    logic                      is_erase;
    lfr_pkg::t_cnt             tail;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign was_present = r_present[i_req.frame_id];
    assign is_insert   = accept && (i_req.op == lfr_pkg::OP_INSERT);
    assign is_victim   = accept && (i_req.op == lfr_pkg::OP_VICTIM)
                         && (r_count != '0);
    assign is_erase    = accept && (i_req.op == lfr_pkg::OP_ERASE) && was_present;
    // A refreshed frame leaves a gap, so it lands one place lower than a new one.
    assign tail        = was_present ? (r_count - 1'b1) : r_count;

    // Cells at or above the hit position close the gap left by the hit.
    always_comb begin
        logic [N-1:0] acc;
        acc = hits;
        for (int k = 0; k < lfr_pkg::LOG_FR; k++) begin
            acc = acc | (acc << (1 << k));
        end
        above = acc;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            always_comb begin
                ctrl[g].shift = is_victim
                                || ((is_erase || (is_insert && was_present)) && above[g]);
                ctrl[g].load  = is_insert && (tail == lfr_pkg::CNT_W'(g));
            end

            lfr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl[g]),
                .i_valid    (r_count > lfr_pkg::CNT_W'(g)),
                .i_key      (i_req.frame_id),
                .i_upper_id ((g == N - 1) ? ids[g] : ids[(g + 1) % N]),
                .o_id       (ids[g]),
                .o_hit      (hits[g])
            );
        end
    endgenerate

    always_comb begin
        n_present = r_present;
        n_count   = r_count;
        n_ok      = 1'b0;
        n_victim  = '0;
        case (i_req.op)
            lfr_pkg::OP_INSERT: begin
                n_ok = 1'b1;
                n_present[i_req.frame_id] = 1'b1;
                if (!was_present) begin
                    n_count = r_count + 1'b1;
                end
            end
            lfr_pkg::OP_VICTIM: begin
                if (r_count != '0) begin
                    n_ok = 1'b1;
                    n_victim = ids[0];
                    n_present[ids[0]] = 1'b0;
                    n_count = r_count - 1'b1;
                end
            end
            lfr_pkg::OP_ERASE: begin
                if (was_present) begin
                    n_ok = 1'b1;
                    n_present[i_req.frame_id] = 1'b0;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_present <= n_present;
                r_count   <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok     <= n_ok;
            r_victim <= n_victim;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_ok;
    assign o_rsp.victim_frame = r_victim;
    assign o_rsp.occupancy    = r_count;

`ifndef SYNTHESIS
    a_count_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_count))
        else $error("entry count disagrees with presence flags");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= N)
        else $error("entry count exceeds list depth");

    a_insert_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_insert |=> r_present[$past(i_req.frame_id)])
        else $error("inserted frame not marked present");

    a_erase_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.op == lfr_pkg::OP_ERASE)) |=> !r_present[$past(i_req.frame_id)])
        else $error("erased frame still marked present");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request stalled with empty response register");
`endif

endmodule

[dv/tb_lru_frame_replacer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LRU frame replacer: directed table, then random traffic.
// Depends on lfr_pkg, the lfr_req_if/lfr_rsp_if channel interfaces and lru_frame_replacer.
module tb_lru_frame_replacer;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int N_DIRECTED   = 23;

    typedef struct packed {
        logic          ok;
        lfr_pkg::t_id  victim_frame;
        lfr_pkg::t_cnt occupancy;
    } t_lru_outcome;

    typedef struct packed {
        lfr_pkg::t_op  op;
        lfr_pkg::t_id  frame_id;
        logic          typed_in;
        logic          ok;
        lfr_pkg::t_id  victim_frame;
        lfr_pkg::t_cnt occupancy;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    lfr_req_if req_if ();
    lfr_rsp_if rsp_if ();

    lru_frame_replacer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Recency list as the block should hold it: rank 0 is the least recent frame.
    lfr_pkg::t_id              rank_frame [lfr_pkg::FRAMES];
    logic [lfr_pkg::FRAMES-1:0] held_mask;
    int unsigned               held_count;

    t_lru_outcome lru_outcome_q[$];
    int           mismatch_count;
    int           cycle_count;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           hold_asked;

    // Rows with typed_in set carry an outcome that is plain from the list contents.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{lfr_pkg::OP_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_ERASE,  6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_ERASE,  6'd63, 1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_NOP,    6'd63, 1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_NOP,    6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_INSERT, 6'd0,  1'b1, 1'b1, 6'd0, 7'd1},
        '{lfr_pkg::OP_INSERT, 6'd63, 1'b1, 1'b1, 6'd0, 7'd2},
        '{lfr_pkg::OP_INSERT, 6'd42, 1'b1, 1'b1, 6'd0, 7'd3},
        '{lfr_pkg::OP_INSERT, 6'd21, 1'b1, 1'b1, 6'd0, 7'd4},
        '{lfr_pkg::OP_INSERT, 6'd0,  1'b1, 1'b1, 6'd0, 7'd4},
        '{lfr_pkg::OP_VICTIM, 6'd5,  1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_NOP,    6'd42, 1'b1, 1'b0, 6'd0, 7'd3},
        '{lfr_pkg::OP_ERASE,  6'd42, 1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_ERASE,  6'd42, 1'b1, 1'b0, 6'd0, 7'd2},
        '{lfr_pkg::OP_INSERT, 6'd63, 1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_VICTIM, 6'd63, 1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_INSERT, 6'd1,  1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_INSERT, 6'd62, 1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_ERASE,  6'd1,  1'b0, 1'b0, 6'd0, 7'd0},
        '{lfr_pkg::OP_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL lru_frame_replacer");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int rank_of(input lfr_pkg::t_id fid);
        int r;
        r = 0;
        for (int k = 0; k < held_count; k++)
            if (rank_frame[k] == fid) r = k;
        return r;
    endfunction

    // Closes the gap left at rank r by moving every more recent frame down one.
    function automatic void drop_rank(input int r);
        for (int k = r; k + 1 < held_count; k++)
            rank_frame[k] = rank_frame[k + 1];
        held_count--;
    endfunction

    function automatic t_lru_outcome recency_update(input lfr_pkg::t_op op,
                                                    input lfr_pkg::t_id fid);
        t_lru_outcome res;
        res = '0;
        case (op)
            lfr_pkg::OP_INSERT: begin
                if (held_mask[fid])
                    drop_rank(rank_of(fid));
                if (held_count < lfr_pkg::FRAMES) begin
                    rank_frame[held_count] = fid;
                    held_count++;
                    held_mask[fid] = 1'b1;
                end
                res.ok = 1'b1;
            end
            lfr_pkg::OP_VICTIM: begin
                if (held_count > 0) begin
                    res.victim_frame = rank_frame[0];
                    drop_rank(0);
                    held_mask[res.victim_frame] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            lfr_pkg::OP_ERASE: begin
                if (held_mask[fid]) begin
                    drop_rank(rank_of(fid));
                    held_mask[fid] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = lfr_pkg::t_cnt'(held_count);
        return res;
    endfunction

    // Offers one request beat and books its outcome once the beat is taken.
    task automatic send_item(input lfr_pkg::t_op op, input lfr_pkg::t_id fid,
                             input logic typed_in, input t_lru_outcome want);
        t_lru_outcome predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= op;
        req_if.frame_id <= fid;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = recency_update(op, fid);
        lru_outcome_q.push_back(typed_in ? want : predicted);
    endtask

    task automatic send_op(input lfr_pkg::t_op op, input lfr_pkg::t_id fid);
        send_item(op, fid, 1'b0, '0);
    endtask

    task automatic wait_for_outcomes();
        int waited;
        waited = 0;
        while (lru_outcome_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Random traffic in episodes: full sweeps of every frame, drains past empty,
    // and mixed stretches leaning towards either filling or emptying the list.
    task automatic run_random(input int n_items);
        int           sent;
        int           kind;
        int           len;
        int           roll;
        int           j;
        lfr_pkg::t_id sweep_ids [lfr_pkg::FRAMES];
        lfr_pkg::t_id tmp;
        lfr_pkg::t_id fid;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
                for (int k = 0; k < lfr_pkg::FRAMES; k++)
                    sweep_ids[k] = lfr_pkg::t_id'(k);
                for (int k = lfr_pkg::FRAMES - 1; k > 0; k--) begin
                    j = $urandom_range(k);
                    tmp = sweep_ids[k];
                    sweep_ids[k] = sweep_ids[j];
                    sweep_ids[j] = tmp;
                end
                for (int k = 0; k < lfr_pkg::FRAMES; k++)
                    send_op(lfr_pkg::OP_INSERT, sweep_ids[k]);
                sent += lfr_pkg::FRAMES;
                if ($urandom_range(1) == 1) begin
                    len = held_count + 1;
                    for (int k = 0; k < len; k++)
                        send_op(lfr_pkg::OP_VICTIM,
                                lfr_pkg::t_id'($urandom_range(lfr_pkg::FRAMES - 1)));
                    sent += len;
                end
            end else begin
                len = $urandom_range(60, 20);
                for (int k = 0; k < len; k++) begin
                    roll = $urandom_range(99);
                    fid  = lfr_pkg::t_id'($urandom_range(lfr_pkg::FRAMES - 1));
                    if (held_count > 0 && $urandom_range(99) < 60)
                        fid = rank_frame[$urandom_range(held_count - 1)];
                    if (roll < 5)
                        send_op(lfr_pkg::OP_NOP, fid);
                    else if (roll < 25)
                        send_op(lfr_pkg::OP_ERASE, fid);
                    else if (roll < (kind < 6 ? 85 : 55))
                        send_op(lfr_pkg::OP_INSERT, fid);
                    else
                        send_op(lfr_pkg::OP_VICTIM, fid);
                end
                sent += len;
            end
        end
    endtask

    // Response side: random back-pressure, plus a long hold-off whenever asked.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lru_outcome exp_beat;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (lru_outcome_q.size() == 0) begin
                flag_mismatch("response beat with nothing outstanding, occupancy",
                              rsp_if.occupancy, -1);
            end else begin
                exp_beat = lru_outcome_q.pop_front();
                if (rsp_if.ok !== exp_beat.ok)
                    flag_mismatch("ok", rsp_if.ok, exp_beat.ok);
                if (rsp_if.victim_frame !== exp_beat.victim_frame)
                    flag_mismatch("victim_frame", rsp_if.victim_frame, exp_beat.victim_frame);
                if (rsp_if.occupancy !== exp_beat.occupancy)
                    flag_mismatch("occupancy", rsp_if.occupancy, exp_beat.occupancy);
            end
        end
    end

    initial begin
        t_stim_row    row;
        t_lru_outcome want;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = lfr_pkg::OP_NOP;
        req_if.frame_id = '0;
        held_mask       = '0;
        held_count      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        hold_asked      = 0;
        tx_idle_pct     = 38;
        rx_idle_pct     = 69;
        for (int k = 0; k < lfr_pkg::FRAMES; k++)
            rank_frame[k] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            want.ok           = row.ok;
            want.victim_frame = row.victim_frame;
            want.occupancy    = row.occupancy;
            send_item(row.op, row.frame_id, row.typed_in, want);
        end
        run_random(580);

        // The sender stands still here until all beats are back or DRAIN_LIMIT runs out.
        req_if.valid <= 1'b0;
        wait_for_outcomes();

        tx_idle_pct = 69;
        rx_idle_pct = 38;
        hold_asked++;
        run_random(580);
        req_if.valid <= 1'b0;
        wait_for_outcomes();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked++;
        run_random(570);
        req_if.valid <= 1'b0;

        wait_for_outcomes();
        repeat (8) @(posedge i_clk);
        if (lru_outcome_q.size() != 0)
            flag_mismatch("outcomes never delivered", lru_outcome_q.size(), 0);
        if (mismatch_count == 0) begin
            $display("PASS lru_frame_replacer");
        end else begin
            $display("FAIL lru_frame_replacer");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lfr_pkg.sv
rtl/lfr_if.sv
rtl/lfr_cell.sv
rtl/lru_frame_replacer.sv
dv/tb_lru_frame_replacer.sv
